// ----- rtl/dual_esc_throttle_ramp_assert.svh -----
// Assertion macros for the dual ESC throttle ramp block.
// Needs clk and rst in the scope of each use; define ASSERT_OFF to drop them.
`ifndef DUAL_ESC_THROTTLE_RAMP_ASSERT_SVH
`define DUAL_ESC_THROTTLE_RAMP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define DTR_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define DTR_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTR_ASSERT_RUN(lbl, prop, msg)
`define DTR_ASSERT_ALL(lbl, prop, msg)
`endif
`endif

// ----- rtl/dtr_pkg.sv -----
// Shared types and constants of the dual ESC throttle ramp block.
// No dependencies; the files that use it take names from here by scope.
package dtr_pkg;

  // Request command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_BOTH  = 2'd1;
  localparam logic [1:0] CMD_LEFT  = 2'd2;
  localparam logic [1:0] CMD_RIGHT = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_US     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_US     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE = 2'd2;

  localparam logic [15:0] MIN_US_RESET     = 16'd1000;
  localparam logic [15:0] MAX_US_RESET     = 16'd2000;
  localparam logic [19:0] ACCEL_RATE_RESET = 20'd0;

  // Level and goal scaling
  localparam logic [23:0] LEVEL_FULL = 24'd10000000;
  localparam logic [23:0] GOAL_SCALE = 24'd1000;
  localparam logic signed [15:0] PCT_FULL = 16'sd10000;
  localparam logic [13:0] GOAL_FULL = 14'd10000;

  // Pulse mapping: q = floor((span*level + 5e6 + 65536e7) / 1e7), less 65536.
  // 1e7 = 128 * 78125: shift out 7 bits, then divide by 78125 through a
  // reciprocal estimate and a remainder correction.
  localparam logic signed [41:0] PULSE_BIAS = 42'sd655365000000;
  localparam logic [23:0]        PULSE_RECIP = 24'd14073748;  // floor(2^40 / 78125)
  localparam logic [16:0]        PULSE_DIV   = 17'd78125;
  localparam logic signed [18:0] Q_BIAS      = 19'sd65536;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // latch the accepted request
    logic calc_step;  // register accel_rate * elapsed_ms
    logic apply;      // update channel state
    logic pulse_sel;  // 0 feeds the left level into the pulse pipe, 1 the right
    logic cap_left;   // capture the left pulse width
    logic cap_right;  // capture the right pulse width
    logic load_out;   // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic set;
    logic tick;
  } chan_cmd_t;

endpackage

// ----- rtl/dtr_if.sv -----
// Request and result channel interfaces of the dual ESC throttle ramp block.
// Plain valid/ready handshake; no dependencies.
interface dtr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] percent;
  logic [31:0]        hold_ms;
  logic               ramp;
  logic [15:0]        elapsed_ms;

  modport source (output valid, cmd, percent, hold_ms, ramp, elapsed_ms, input ready);
  modport sink   (input valid, cmd, percent, hold_ms, ramp, elapsed_ms, output ready);
endinterface

interface dtr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_us;
  logic [15:0] right_us;
  logic [23:0] left_level;
  logic [23:0] right_level;
  logic        motors_off;

  modport source (output valid, left_us, right_us, left_level, right_level, motors_off,
                  input ready);
  modport sink   (input valid, left_us, right_us, left_level, right_level, motors_off,
                  output ready);
endinterface

// ----- rtl/dtr_ctrl.sv -----
// Sequencing controller of the dual ESC throttle ramp block.
// Depends on dtr_pkg for the command struct.
module dtr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dtr_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_PULSE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [2:0] CNT_CAP_L = 3'd5;
  localparam logic [2:0] CNT_CAP_R = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_STEP;
        end
      end
      S_STEP: begin
        cmd.calc_step = 1'b1;
        state_next    = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        cnt_next   = '0;
        state_next = S_PULSE;
      end
      S_PULSE: begin
        cmd.pulse_sel = (cnt == 3'd1);
        cmd.cap_left  = (cnt == CNT_CAP_L);
        cmd.cap_right = (cnt == CNT_CAP_R);
        cnt_next      = cnt + 3'd1;
        if (cnt == CNT_CAP_R) state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/dtr_chan.sv -----
// One throttle channel: level, goal and hold timer with their update logic.
// Depends on dtr_pkg for the channel command and scaling constants.
module dtr_chan (
  input  logic               clk,
  input  logic               rst,
  input  dtr_pkg::chan_cmd_t cmd,
  input  logic [13:0]        goal_in,
  input  logic [31:0]        hold_in,
  input  logic               ramp_in,
  input  logic [15:0]        elapsed,
  input  logic               accel_zero,
  input  logic [35:0]        step,
  output logic [23:0]        level
);

  logic [23:0] now;
  logic [13:0] goal;
  logic [31:0] hold_remaining;
  logic        hold_active;

  logic        expire;
  logic [13:0] goal_eff;
  logic [23:0] tgt, set_lvl, diff, moved;
  logic        up, reach;

  assign level = now;

  always_comb begin
    expire   = hold_active && ({16'b0, elapsed} >= hold_remaining);
    goal_eff = expire ? '0 : goal;
    tgt      = {10'b0, goal_eff} * dtr_pkg::GOAL_SCALE;
    set_lvl  = {10'b0, goal_in} * dtr_pkg::GOAL_SCALE;
    up       = (tgt >= now);
    diff     = up ? (tgt - now) : (now - tgt);
    reach    = ({12'b0, diff} <= step);
    // a step short of the target stays below 2^24, so its low bits suffice
    if (reach)   moved = tgt;
    else if (up) moved = now + step[23:0];
    else         moved = now - step[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now            <= '0;
      goal           <= '0;
      hold_remaining <= '0;
      hold_active    <= 1'b0;
    end else if (cmd.set) begin
      goal           <= goal_in;
      hold_active    <= (hold_in != '0);
      hold_remaining <= hold_in;
      if (!ramp_in) now <= set_lvl;
    end else if (cmd.tick) begin
      if (hold_active) begin
        if (expire) begin
          hold_active    <= 1'b0;
          hold_remaining <= '0;
          goal           <= '0;
        end else begin
          hold_remaining <= hold_remaining - {16'b0, elapsed};
        end
      end
      if (elapsed != '0) now <= accel_zero ? tgt : moved;
    end
  end

endmodule

// ----- rtl/dtr_pulse.sv -----
// Five-stage pipeline mapping a level to a rounded, clamped pulse width.
// Depends on dtr_pkg for the division constants.
module dtr_pulse (
  input  logic        clk,
  input  logic [23:0] level,
  input  logic [15:0] min_us,
  input  logic [15:0] max_us,
  output logic [15:0] us
);

  logic signed [16:0] span;
  logic signed [41:0] prod;
  logic signed [41:0] num;
  logic [33:0]        y2, y3, y4;
  logic [41:0]        m3;
  logic [17:0]        qe4, q5;
  logic [34:0]        qm4, rem;
  logic signed [18:0] sum, lo;

  assign span = $signed({1'b0, max_us}) - $signed({1'b0, min_us});
  assign num  = prod + dtr_pkg::PULSE_BIAS;
  assign rem  = {1'b0, y4} - qm4;

  always_ff @(posedge clk) begin
    prod <= 42'(span * $signed({1'b0, level}));
    // biased numerator is nonnegative and below 2^41; drop the factor of 128
    y2   <= num[40:7];
    m3   <= 42'(y2[33:16]) * 42'(dtr_pkg::PULSE_RECIP);
    y3   <= y2;
    qe4  <= m3[41:24];
    qm4  <= 35'(m3[41:24]) * 35'(dtr_pkg::PULSE_DIV);
    y4   <= y3;
    // estimate falls short by at most two
    q5   <= qe4 + 18'(rem >= 35'(dtr_pkg::PULSE_DIV))
                + 18'(rem >= (35'(dtr_pkg::PULSE_DIV) << 1));
  end

  always_comb begin
    sum = $signed({3'b0, min_us}) + $signed({1'b0, q5}) - dtr_pkg::Q_BIAS;
    // clamp up to min first, then down to max
    lo  = (sum < $signed({3'b0, min_us})) ? $signed({3'b0, min_us}) : sum;
    if (lo > $signed({3'b0, max_us})) us = max_us;
    else                              us = lo[15:0];
  end

endmodule

// ----- rtl/dtr_dpath.sv -----
// Datapath: configuration, request register, step multiplier, two channels,
// shared pulse pipeline and the result register. Uses dtr_pkg, dtr_chan, dtr_pulse.
module dtr_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  dtr_pkg::ctrl_cmd_t               cmd,
  input  logic                             cfg_we,
  input  logic [dtr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       in_cmd,
  input  logic signed [15:0]               in_percent,
  input  logic [31:0]                      in_hold_ms,
  input  logic                             in_ramp,
  input  logic [15:0]                      in_elapsed_ms,
  output logic [15:0]                      left_us,
  output logic [15:0]                      right_us,
  output logic [23:0]                      left_level,
  output logic [23:0]                      right_level,
  output logic                             motors_off
);

  logic [15:0] min_us, max_us;
  logic [19:0] accel_rate;

  logic [1:0]  cmd_r;
  logic [13:0] goal_r, goal_clamp;
  logic [31:0] hold_r;
  logic        ramp_r;
  logic [15:0] elapsed_r;
  logic [35:0] step_r;

  dtr_pkg::chan_cmd_t lcmd, rcmd;
  logic [23:0] lnow, rnow, plevel;
  logic [15:0] pus, lus_r, rus_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_us     <= dtr_pkg::MIN_US_RESET;
      max_us     <= dtr_pkg::MAX_US_RESET;
      accel_rate <= dtr_pkg::ACCEL_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dtr_pkg::REG_MIN_US:     min_us     <= cfg_data[15:0];
        dtr_pkg::REG_MAX_US:     max_us     <= cfg_data[15:0];
        dtr_pkg::REG_ACCEL_RATE: accel_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_percent < 16'sd0)                  goal_clamp = '0;
    else if (in_percent > dtr_pkg::PCT_FULL)  goal_clamp = dtr_pkg::GOAL_FULL;
    else                                      goal_clamp = in_percent[13:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r     <= in_cmd;
      goal_r    <= goal_clamp;
      hold_r    <= in_hold_ms;
      ramp_r    <= in_ramp;
      elapsed_r <= in_elapsed_ms;
    end
    if (cmd.calc_step) step_r <= 36'(accel_rate) * 36'(elapsed_r);
  end

  always_comb begin
    lcmd.tick = cmd.apply && (cmd_r == dtr_pkg::CMD_TICK);
    rcmd.tick = lcmd.tick;
    lcmd.set  = cmd.apply && (cmd_r == dtr_pkg::CMD_BOTH || cmd_r == dtr_pkg::CMD_LEFT);
    rcmd.set  = cmd.apply && (cmd_r == dtr_pkg::CMD_BOTH || cmd_r == dtr_pkg::CMD_RIGHT);
  end

  dtr_chan u_left (
    .clk, .rst, .cmd(lcmd), .goal_in(goal_r), .hold_in(hold_r), .ramp_in(ramp_r),
    .elapsed(elapsed_r), .accel_zero(accel_rate == '0), .step(step_r), .level(lnow)
  );

  dtr_chan u_right (
    .clk, .rst, .cmd(rcmd), .goal_in(goal_r), .hold_in(hold_r), .ramp_in(ramp_r),
    .elapsed(elapsed_r), .accel_zero(accel_rate == '0), .step(step_r), .level(rnow)
  );

  assign plevel = cmd.pulse_sel ? rnow : lnow;

  dtr_pulse u_pulse (
    .clk, .level(plevel), .min_us, .max_us, .us(pus)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_left)  lus_r <= pus;
    if (cmd.cap_right) rus_r <= pus;
    if (cmd.load_out) begin
      left_us     <= lus_r;
      right_us    <= rus_r;
      left_level  <= lnow;
      right_level <= rnow;
      motors_off  <= (lnow == '0) && (rnow == '0);
    end
  end

endmodule

// ----- rtl/dual_esc_throttle_ramp.sv -----
// Dual ESC throttle ramp top level: controller, datapath and assertions.
// Uses dtr_pkg, dtr_if, dtr_ctrl, dtr_dpath and dual_esc_throttle_ramp_assert.svh.
//
// Usage: requests arrive on the items channel (valid/ready). cmd selects a tick
// (elapsed_ms moves both levels toward their goals and runs the hold timers) or
// a set of both, left or right channel (percent, hold_ms, ramp). Every request
// yields exactly one result on the results channel: both pulse widths, both
// levels and motors_off.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 min_us,
// 1 max_us, 2 accel_rate); other indexes are ignored. Write only while idle.
// Sequence: each request passes through latch, step multiply, state update, a
// five-stage pulse pipeline shared by both channels (the left level enters it
// first, then the right), then the result load. No new request is accepted
// until the current one has reached its result load.
// A result waiting in the output register does not block the next request; only
// the result load of that next request waits until the receiver takes the old one.
// Reset: synchronous, active high; levels, goals and hold timers clear, the
// configuration returns to 1000 / 2000 / 0 and no result is pending.
`include "dual_esc_throttle_ramp_assert.svh"
module dual_esc_throttle_ramp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dtr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  dtr_in_if.sink                          items,
  dtr_out_if.source                       results
);

  dtr_pkg::ctrl_cmd_t ctl_cmd;

  // sequence each request: latch, multiply, update, pulse, load
  dtr_ctrl u_ctrl (
    .clk,
    .rst,
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (ctl_cmd)
  );

  // hold state and compute results under controller commands
  dtr_dpath u_dpath (
    .clk,
    .rst,
    .cmd           (ctl_cmd),
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_cmd        (items.cmd),
    .in_percent    (items.percent),
    .in_hold_ms    (items.hold_ms),
    .in_ramp       (items.ramp),
    .in_elapsed_ms (items.elapsed_ms),
    .left_us       (results.left_us),
    .right_us      (results.right_us),
    .left_level    (results.left_level),
    .right_level   (results.right_level),
    .motors_off    (results.motors_off)
  );

  // a pending result is never overwritten
  `DTR_ASSERT_RUN(a_no_overwrite, ctl_cmd.load_out |-> !(results.valid && !results.ready), "result overwritten while pending")
  // one request at a time
  `DTR_ASSERT_RUN(a_one_at_a_time, (items.valid && items.ready) |=> !items.ready, "request accepted while busy")
  // levels stay within full throttle
  `DTR_ASSERT_RUN(a_level_range, results.valid |-> (results.left_level <= dtr_pkg::LEVEL_FULL && results.right_level <= dtr_pkg::LEVEL_FULL), "level above full throttle")
  // reset drops any pending result
  `DTR_ASSERT_ALL(a_reset_clear, rst |=> !results.valid, "result valid after reset")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the dual ESC throttle ramp block: directed and random requests.
// Depends on dtr_pkg, the dtr_in_if / dtr_out_if interfaces and dual_esc_throttle_ramp.
module tb_top;

  // Channel slots in the predicted state
  localparam int CH_LEFT  = 0;
  localparam int CH_RIGHT = 1;
  // Unused register index; writes to it must leave every register untouched
  localparam logic [dtr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Percent of cycles in which either side sits out
  localparam int IDLE_PCT = 23;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] percent;
    logic [31:0]        hold_ms;
    logic               ramp;
    logic [15:0]        elapsed_ms;
  } esc_request_t;

  typedef struct {
    logic [15:0] left_us;
    logic [15:0] right_us;
    logic [23:0] left_level;
    logic [23:0] right_level;
    logic        motors_off;
  } throttle_report_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [dtr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dtr_pkg::CFG_DATA_W-1:0] cfg_data;

  dtr_in_if  items_bus ();
  dtr_out_if results_bus ();

  dual_esc_throttle_ramp DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_bus),
    .results   (results_bus)
  );

  // Predicted block state and configuration
  logic [23:0] level_now [2];
  logic [13:0] goal_pct  [2];
  logic [31:0] hold_left [2];
  logic        hold_on   [2];
  logic [15:0] min_us_cfg;
  logic [15:0] max_us_cfg;
  logic [19:0] accel_cfg;

  esc_request_t     request_backlog [$];
  throttle_report_t pending_reports [$];

  int   fail_count;
  int   accepted_count;
  logic quiet_mode;   // no idling on either side while set
  logic sink_hold;    // receiver holds off while set

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Map a level to a pulse width: round half up exactly, then clamp up to
  // min_us first and down to max_us second (inverted bounds end at max_us).
  function automatic logic [15:0] pulse_width(input logic [23:0] level);
    longint span, num, q, us;
    span = longint'(max_us_cfg) - longint'(min_us_cfg);
    num  = span * longint'(level) + 64'sd5000000;
    q    = num / 10000000;
    // Division truncates toward zero; pull negative quotients down to floor
    if (num % 10000000 != 0 && num < 0) q--;
    us = longint'(min_us_cfg) + q;
    if (us < longint'(min_us_cfg)) us = longint'(min_us_cfg);
    if (us > longint'(max_us_cfg)) us = longint'(max_us_cfg);
    return us[15:0];
  endfunction

  function automatic void set_channel(input int ch, input logic [13:0] goal,
                                      input logic [31:0] hold, input logic ramp);
    goal_pct[ch]  = goal;
    hold_on[ch]   = (hold != 0);
    hold_left[ch] = hold;
    // Jump at once unless the request asks for a ramp
    if (!ramp) level_now[ch] = goal * dtr_pkg::GOAL_SCALE;
  endfunction

  function automatic void tick_channel(input int ch, input logic [15:0] elapsed);
    longint target, stride, gap;
    // Expire the hold first, even on a zero elapsed tick
    if (hold_on[ch]) begin
      if (elapsed >= hold_left[ch]) begin
        hold_on[ch]   = 1'b0;
        hold_left[ch] = '0;
        goal_pct[ch]  = '0;
      end else begin
        hold_left[ch] = hold_left[ch] - elapsed;
      end
    end
    if (elapsed == 0) return;
    target = longint'(goal_pct[ch]) * 1000;
    if (accel_cfg == 0) begin
      level_now[ch] = 24'(target);
      return;
    end
    stride = longint'(accel_cfg) * longint'(elapsed);
    gap    = target - longint'(level_now[ch]);
    if (gap >= 0)
      level_now[ch] = (gap <= stride) ? 24'(target) : 24'(longint'(level_now[ch]) + stride);
    else
      level_now[ch] = (-gap <= stride) ? 24'(target) : 24'(longint'(level_now[ch]) - stride);
  endfunction

  // Advance the predicted state by one accepted request and queue its report
  function automatic void predict_throttle(input esc_request_t req);
    logic [13:0]      goal;
    throttle_report_t rpt;
    if (req.percent < 0)                      goal = '0;
    else if (req.percent > dtr_pkg::PCT_FULL) goal = dtr_pkg::GOAL_FULL;
    else                                      goal = req.percent[13:0];
    case (req.cmd)
      dtr_pkg::CMD_TICK: begin
        tick_channel(CH_LEFT, req.elapsed_ms);
        tick_channel(CH_RIGHT, req.elapsed_ms);
      end
      dtr_pkg::CMD_BOTH: begin
        set_channel(CH_LEFT, goal, req.hold_ms, req.ramp);
        set_channel(CH_RIGHT, goal, req.hold_ms, req.ramp);
      end
      dtr_pkg::CMD_LEFT:  set_channel(CH_LEFT, goal, req.hold_ms, req.ramp);
      dtr_pkg::CMD_RIGHT: set_channel(CH_RIGHT, goal, req.hold_ms, req.ramp);
      default: ;
    endcase
    rpt.left_us     = pulse_width(level_now[CH_LEFT]);
    rpt.right_us    = pulse_width(level_now[CH_RIGHT]);
    rpt.left_level  = level_now[CH_LEFT];
    rpt.right_level = level_now[CH_RIGHT];
    rpt.motors_off  = (level_now[CH_LEFT] == 0) && (level_now[CH_RIGHT] == 0);
    pending_reports.push_back(rpt);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_request(input logic [1:0] cmd, input logic signed [15:0] pct,
                                      input logic [31:0] hold, input logic ramp,
                                      input logic [15:0] elapsed);
    esc_request_t req;
    req.cmd        = cmd;
    req.percent    = pct;
    req.hold_ms    = hold;
    req.ramp       = ramp;
    req.elapsed_ms = elapsed;
    request_backlog.push_back(req);
  endfunction

  // Random request: mostly in-range goals, short holds and short ticks so that
  // holds expire and ramps finish; the rest spans the full field ranges.
  // Fields a command ignores still carry random content.
  function automatic esc_request_t random_request();
    esc_request_t req;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      req.cmd = dtr_pkg::CMD_TICK;
    else if (pick < 65) req.cmd = dtr_pkg::CMD_BOTH;
    else if (pick < 82) req.cmd = dtr_pkg::CMD_LEFT;
    else                req.cmd = dtr_pkg::CMD_RIGHT;
    case ($urandom_range(0, 9))
      6: req.percent = 16'($urandom);
      7: case ($urandom_range(0, 5))
           0: req.percent = 16'sd0;
           1: req.percent = 16'sd10000;
           2: req.percent = -16'sd1;
           3: req.percent = 16'sd10001;
           4: req.percent = 16'sh8000;
           default: req.percent = 16'sh7FFF;
         endcase
      8: req.percent = 16'($urandom_range(9900, 10000));
      9: req.percent = 16'($urandom_range(0, 100));
      default: req.percent = 16'($urandom_range(0, 10000));
    endcase
    case ($urandom_range(0, 9))
      4, 5, 6: req.hold_ms = $urandom_range(1, 300);
      7:       req.hold_ms = $urandom_range(1, 5000);
      8:       req.hold_ms = $urandom;
      9:       req.hold_ms = 32'hFFFF_FFFF;
      default: req.hold_ms = '0;
    endcase
    req.ramp = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0, 1:    req.elapsed_ms = '0;
      7, 8:    req.elapsed_ms = 16'($urandom_range(101, 3000));
      9:       req.elapsed_ms = 16'($urandom);
      default: req.elapsed_ms = 16'($urandom_range(1, 100));
    endcase
    return req;
  endfunction

  task automatic fill_random(input int count);
    @(negedge clk);
    repeat (count) request_backlog.push_back(random_request());
  endtask

  // Drive one register write and mirror it into the predictor
  task automatic write_register(input logic [dtr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dtr_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      dtr_pkg::REG_MIN_US:     min_us_cfg = data[15:0];
      dtr_pkg::REG_MAX_US:     max_us_cfg = data[15:0];
      dtr_pkg::REG_ACCEL_RATE: accel_cfg  = data[19:0];
      default: ;
    endcase
  endtask

  // Write all three registers back to back, poke the spare index, then drop the enable
  task automatic set_registers(input logic [19:0] lo, input logic [19:0] hi,
                               input logic [19:0] rate);
    write_register(dtr_pkg::REG_MIN_US, lo);
    write_register(dtr_pkg::REG_MAX_US, hi);
    write_register(dtr_pkg::REG_ACCEL_RATE, rate);
    write_register(REG_SPARE, 20'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every request is taken and every report is back,
  // then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (request_backlog.size() != 0 || items_bus.valid || pending_reports.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------

  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("dual_esc_throttle_ramp verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: pop the backlog, hold valid until the block takes the
  // request, predict on acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_requests
    esc_request_t offered;
    if (rst) begin
      items_bus.valid <= 1'b0;
    end else begin
      if (items_bus.valid && items_bus.ready) begin
        predict_throttle(offered);
        accepted_count++;
      end
      // Slot is free once nothing is offered or the offer was just taken
      if (!items_bus.valid || items_bus.ready) begin
        if (request_backlog.size() != 0 &&
            (quiet_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = request_backlog.pop_front();
          items_bus.valid      <= 1'b1;
          items_bus.cmd        <= offered.cmd;
          items_bus.percent    <= offered.percent;
          items_bus.hold_ms    <= offered.hold_ms;
          items_bus.ramp       <= offered.ramp;
          items_bus.elapsed_ms <= offered.elapsed_ms;
        end else begin
          items_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report monitor: compare each taken report with the oldest prediction and
  // toggle ready at random
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watch_reports
    throttle_report_t want;
    if (rst) begin
      results_bus.ready <= 1'b0;
    end else begin
      if (results_bus.valid && results_bus.ready) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          $error("report with no request outstanding");
        end else begin
          want = pending_reports.pop_front();
          check_field("left_us", 32'(want.left_us), 32'(results_bus.left_us));
          check_field("right_us", 32'(want.right_us), 32'(results_bus.right_us));
          check_field("left_level", 32'(want.left_level), 32'(results_bus.left_level));
          check_field("right_level", 32'(want.right_level),
                      32'(results_bus.right_level));
          check_field("motors_off", 32'(want.motors_off), 32'(results_bus.motors_off));
        end
      end
      results_bus.ready <= !sink_hold && (quiet_mode || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Back-pressure burst: once the random traffic is flowing, hold off the
  // receiver long enough for the block to fill and stall its input
  initial begin : long_stall
    sink_hold = 1'b0;
    do @(negedge clk);
    while (accepted_count < 300);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    // Known values on every block input from time zero
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    items_bus.valid      = 1'b0;
    items_bus.cmd        = dtr_pkg::CMD_TICK;
    items_bus.percent    = '0;
    items_bus.hold_ms    = '0;
    items_bus.ramp       = 1'b0;
    items_bus.elapsed_ms = '0;
    results_bus.ready    = 1'b0;
    quiet_mode           = 1'b0;
    fail_count           = 0;
    accepted_count       = 0;
    // Predictor starts from the reset state
    for (int ch = 0; ch < 2; ch++) begin
      level_now[ch] = '0;
      goal_pct[ch]  = '0;
      hold_left[ch] = '0;
      hold_on[ch]   = 1'b0;
    end
    min_us_cfg = dtr_pkg::MIN_US_RESET;
    max_us_cfg = dtr_pkg::MAX_US_RESET;
    accel_cfg  = dtr_pkg::ACCEL_RATE_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration, snap mode: jumps, clamps and hold expiry
    @(negedge clk);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd0);        // zero tick from reset
    add_request(dtr_pkg::CMD_BOTH, 16'sd10000, 32'd0, 1'b0, 16'd0);    // full throttle at once
    add_request(dtr_pkg::CMD_LEFT, 16'sh8000, 32'd0, 1'b0, 16'hFFFF);  // most negative goal
    add_request(dtr_pkg::CMD_RIGHT, 16'sh7FFF, 32'd5, 1'b1, 16'd0);    // top goal, short hold
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd3);        // hold counts down
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd0);        // zero tick checks expiry
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd2);        // elapsed equals remaining
    add_request(dtr_pkg::CMD_LEFT, 16'sd1, 32'd0, 1'b0, 16'd0);        // smallest nonzero level
    add_request(dtr_pkg::CMD_RIGHT, 16'sd5000, 32'hFFFF_FFFF, 1'b0, 16'd0); // longest hold
    add_request(dtr_pkg::CMD_LEFT, 16'sd10001, 32'd1, 1'b1, 16'd0);    // just above full
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b1, 16'hFFFF);     // longest tick
    wait_idle();

    // Inverted bounds and a ramp rate above its nominal range
    set_registers(20'd2000, 20'd1000, 20'hFFFFF);
    @(negedge clk);
    add_request(dtr_pkg::CMD_BOTH, 16'sd5000, 32'd0, 1'b0, 16'd0);
    add_request(dtr_pkg::CMD_LEFT, 16'sd10000, 32'd0, 1'b1, 16'd0);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd1);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'hFFFF);
    add_request(dtr_pkg::CMD_RIGHT, 16'sd0, 32'd0, 1'b1, 16'd0);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd3);
    wait_idle();

    // Equal bounds and the slowest ramp
    set_registers(20'd1500, 20'd1500, 20'd1);
    @(negedge clk);
    add_request(dtr_pkg::CMD_BOTH, 16'sd7777, 32'd0, 1'b0, 16'd0);
    add_request(dtr_pkg::CMD_LEFT, 16'sd0, 32'd0, 1'b1, 16'd0);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'hFFFF);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd0);
    wait_idle();

    // Widest span, nominal top rate, hold expiring on an exact match
    set_registers(20'd0, 20'd65535, 20'd1000000);
    @(negedge clk);
    add_request(dtr_pkg::CMD_LEFT, 16'sd3333, 32'd10, 1'b1, 16'd0);
    add_request(dtr_pkg::CMD_RIGHT, 16'sd100, 32'd0, 1'b0, 16'd0);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd9);
    add_request(dtr_pkg::CMD_TICK, 16'sd0, 32'd0, 1'b0, 16'd1);
    wait_idle();

    // Random phases, each under its own configuration
    set_registers(20'd0, 20'd65535, 20'd20000);
    fill_random(240);
    wait_idle();

    // Inverted extremes; the receiver burst lands in this phase
    set_registers({4'($urandom), 16'hFFFF}, {4'($urandom), 16'h0000}, 20'd1);
    fill_random(240);
    wait_idle();

    // Back-to-back traffic with no idling on either side
    quiet_mode <= 1'b1;
    set_registers(20'($urandom), 20'($urandom), 20'hFFFFF);
    fill_random(240);
    wait_idle();
    quiet_mode <= 1'b0;

    set_registers(20'($urandom_range(0, 3000)), 20'($urandom_range(0, 65535)),
                  20'($urandom_range(100, 5000)));
    fill_random(240);
    wait_idle();

    // Back to the reset values
    set_registers(20'(dtr_pkg::MIN_US_RESET), 20'(dtr_pkg::MAX_US_RESET),
                  20'(dtr_pkg::ACCEL_RATE_RESET));
    fill_random(240);
    wait_idle();

    if (pending_reports.size() != 0) begin
      fail_count++;
      $error("%0d reports never arrived", pending_reports.size());
    end
    if (fail_count == 0) begin
      $display("dual_esc_throttle_ramp verification clean");
    end else begin
      $display("dual_esc_throttle_ramp verification failed");
    end
    $finish;
  end

endmodule
